### design/sfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_PAYLOAD = 1024;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HELD = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    localparam logic [7:0]  START_BYTE = 8'hAA;
    localparam logic [7:0]  END_BYTE   = 8'h55;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic [9:0] read_index;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'd0, d};
        for (int b = 0; b < 8; b++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/sfr_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_cmd_fifo
// Short command queue between the input front and the frame engine.
// ----------------------------------------------------------------------------
module sfr_cmd_fifo
    import sfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_valid,
    output logic      o_wr_ready,
    input  wire t_cmd i_wr_data,
    output logic      o_rd_valid,
    input  wire logic i_rd_ready,
    output t_cmd      o_rd_data
);
    t_cmd       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_wr_ready = (r_cnt != 3'd4);
    assign o_rd_valid = (r_cnt != 3'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 2'd1;
            if (w_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, w_wr} - {2'd0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_wr_data;
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("queue count overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[1:0] == r_wp - r_rp) else $error("pointer mismatch");
    a_full_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd4 && !w_rd) |=> r_cnt == 3'd4) else $error("full lost");
endmodule
`default_nettype wire

### design/sfr_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_engine
// Byte store, frame scanner with serial CRC check, and result register.
// ----------------------------------------------------------------------------
module sfr_engine
    import sfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [10:0] i_capacity,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_ready,
    input  wire t_cmd        i_cmd,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_read_data,
    output logic [10:0]      o_payload_length,
    output logic [31:0]      o_frames_received,
    output logic [31:0]      o_error_count
);
    localparam int DEPTH = MAX_PAYLOAD + 6;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_LEN1 = 4'd3;
    localparam logic [3:0] S_LEN2 = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_CRC  = 4'd6;
    localparam logic [3:0] S_CL   = 4'd7;
    localparam logic [3:0] S_CH   = 4'd8;
    localparam logic [3:0] S_END  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;
    localparam logic [3:0] S_WAIT = 4'd11;

    // circular byte store: head pointer plus count
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_q;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] w_raddr;
    logic [AW:0]   w_rsum;
    logic [CW-1:0] r_off;
    logic          r_rd_en;

    logic [3:0]    r_state;
    logic          r_held;
    logic [10:0]   r_hlen;
    logic [15:0]   r_flen;
    logic [15:0]   r_len;
    logic [15:0]   r_crc;
    logic [15:0]   r_idx;
    logic [7:0]    r_clo;
    logic [31:0]   r_valid_cnt, r_rej_cnt;
    logic [1:0]    r_status;
    logic [7:0]    r_data;
    logic          r_out_v;
    logic [1:0]    r_res_status;
    logic [7:0]    r_res_data;
    logic [10:0]   r_res_len;
    logic [31:0]   r_res_frames;
    logic [31:0]   r_res_errors;
    logic [10:0]   w_cap;
    logic [15:0]   w_flen;
    logic [AW:0]   w_wsum;
    logic [AW-1:0] w_waddr;

    assign w_rsum  = {1'b0, r_head} + (AW+1)'(r_off);
    assign w_raddr = (w_rsum >= (AW+1)'(DEPTH)) ? AW'(w_rsum - (AW+1)'(DEPTH)) : w_rsum[AW-1:0];
    assign w_wsum  = {1'b0, r_head} + (AW+1)'(r_count);
    assign w_waddr = (w_wsum >= (AW+1)'(DEPTH)) ? AW'(w_wsum - (AW+1)'(DEPTH)) : w_wsum[AW-1:0];
    assign w_cap   = (i_capacity == 11'd0) ? 11'd0 : i_capacity - 11'd1;
    assign w_flen  = r_len + 16'd6;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid && i_cmd.op == OP_PUSH &&
            r_count != CW'(DEPTH)) begin
            r_mem[w_waddr] <= i_cmd.rx_byte;
        end
        if (r_rd_en) r_q <= r_mem[w_raddr];
    end

    assign o_cmd_ready = (r_state == S_IDLE);

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [15:0] n);
        logic [AW+16:0] s;
        s = {17'd0, p} + {{(AW+1){1'b0}}, n};
        s = (s >= (AW+17)'(DEPTH)) ? s - (AW+17)'(DEPTH) : s;
        return s[AW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_count <= '0;
            r_held <= 1'b0;
            r_hlen <= '0;
            r_valid_cnt <= '0;
            r_rej_cnt <= '0;
            r_out_v <= 1'b0;
            r_rd_en <= 1'b0;
            r_off <= '0;
        end else begin
            r_rd_en <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_data <= 8'd0;
                        r_status <= r_held ? ST_HELD : ST_IDLE;
                        r_state <= S_OUT;
                        priority case (i_cmd.op)
                            OP_PUSH: begin
                                if (r_count == CW'(DEPTH)) begin
                                    r_status <= ST_DROP;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                    if (!r_held) begin
                                        r_state <= S_SCAN;
                                        r_off <= '0;
                                        r_rd_en <= 1'b1;
                                    end
                                end
                            end
                            OP_READ: begin
                                if (r_held && {1'b0, i_cmd.read_index} < r_hlen) begin
                                    r_off <= CW'(i_cmd.read_index) + CW'(3);
                                    r_rd_en <= 1'b1;
                                    r_state <= S_RD;
                                end
                            end
                            OP_RELEASE: begin
                                if (r_held) begin
                                    r_head <= adv(r_head, r_flen);
                                    r_count <= r_count - CW'(r_flen);
                                    r_held <= 1'b0;
                                    r_hlen <= '0;
                                    r_off <= '0;
                                    r_rd_en <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: r_state <= S_WAIT;
                S_WAIT: begin
                    r_data <= r_q;
                    r_state <= S_OUT;
                end
                S_SCAN: begin
                    // hold until the head byte lands
                    if (!r_rd_en) begin
                        if (r_count == '0) begin
                            r_state <= S_OUT;
                        end else if (r_q != START_BYTE) begin
                            r_head <= adv(r_head, 16'd1);
                            r_count <= r_count - CW'(1);
                            r_state <= S_LEN1;
                            r_off <= '0;
                            r_rd_en <= 1'b1;
                            r_idx <= 16'hFFFF;
                        end else if (r_count < CW'(3)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_off <= CW'(1);
                            r_rd_en <= 1'b1;
                            r_idx <= 16'd0;
                            r_state <= S_LEN1;
                        end
                    end
                end
                S_LEN1: begin
                    if (r_idx == 16'hFFFF) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_off <= CW'(2);
                        r_rd_en <= 1'b1;
                        r_state <= S_LEN2;
                        r_idx <= 16'd1;
                    end
                end
                S_LEN2: begin
                    if (r_idx == 16'd1) begin
                        r_len[15:8] <= r_q;
                        r_idx <= 16'd2;
                    end else begin
                        r_len[7:0] <= r_q;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_len > 16'(MAX_PAYLOAD)) begin
                        r_rej_cnt <= r_rej_cnt + 32'd1;
                        r_head <= adv(r_head, 16'd1);
                        r_count <= r_count - CW'(1);
                        r_off <= '0;
                        r_rd_en <= 1'b1;
                        r_idx <= 16'hFFFF;
                        r_state <= S_LEN1;
                    end else if ({{(17-CW){1'b0}}, r_count} < {1'b0, w_flen}) begin
                        r_state <= S_OUT;
                    end else begin
                        r_crc <= CRC_INIT;
                        r_idx <= 16'd0;
                        r_off <= CW'(3);
                        r_rd_en <= 1'b1;
                        r_state <= S_CRC;
                    end
                end
                S_CRC: begin
                    // r_idx indexes the payload byte whose read is in flight; data lands in r_q once r_rd_en drops
                    if (!r_rd_en) begin
                        if (r_idx != r_len) r_crc <= crc_byte(r_crc, r_q);
                        if (r_idx == r_len) begin
                            r_off <= CW'(r_len) + CW'(3);
                            r_rd_en <= 1'b1;
                            r_state <= S_CL;
                        end else begin
                            r_off <= CW'(r_idx) + CW'(4);
                            r_idx <= r_idx + 16'd1;
                            r_rd_en <= 1'b1;
                        end
                    end
                end
                S_CL: begin
                    if (!r_rd_en) begin
                        r_clo <= r_q;
                        r_off <= CW'(r_len) + CW'(4);
                        r_rd_en <= 1'b1;
                        r_state <= S_CH;
                    end
                end
                S_CH: begin
                    if (!r_rd_en) begin
                        if ({r_q, r_clo} != r_crc) begin
                            r_rej_cnt <= r_rej_cnt + 32'd1;
                            r_head <= adv(r_head, 16'd1);
                            r_count <= r_count - CW'(1);
                            r_off <= '0;
                            r_rd_en <= 1'b1;
                            r_idx <= 16'hFFFF;
                            r_state <= S_LEN1;
                        end else begin
                            r_off <= CW'(r_len) + CW'(5);
                            r_rd_en <= 1'b1;
                            r_state <= S_END;
                        end
                    end
                end
                S_END: begin
                    if (!r_rd_en) begin
                        if (r_q != END_BYTE) begin
                            r_rej_cnt <= r_rej_cnt + 32'd1;
                            r_head <= adv(r_head, 16'd1);
                            r_count <= r_count - CW'(1);
                            r_off <= '0;
                            r_rd_en <= 1'b1;
                            r_idx <= 16'hFFFF;
                            r_state <= S_LEN1;
                        end else begin
                            r_held <= 1'b1;
                            r_flen <= w_flen;
                            r_hlen <= (r_len[10:0] < w_cap) ? r_len[10:0] : w_cap;
                            r_valid_cnt <= r_valid_cnt + 32'd1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_v || i_res_ready) begin
                        r_out_v <= 1'b1;
                        r_res_status <= (r_status == ST_DROP) ? ST_DROP :
                                        (r_held ? ST_HELD : ST_IDLE);
                        r_res_data <= r_data;
                        r_res_len <= r_hlen;
                        r_res_frames <= r_valid_cnt;
                        r_res_errors <= r_rej_cnt;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_out_v && i_res_ready && !(r_state == S_OUT)) r_out_v <= 1'b0;
        end
    end

    assign o_res_valid       = r_out_v;
    assign o_status          = r_res_status;
    assign o_read_data       = r_res_data;
    assign o_payload_length  = r_res_len;
    assign o_frames_received = r_res_frames;
    assign o_error_count     = r_res_errors;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("store overflow");
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held |-> r_hlen == '0) else $error("length without frame");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> r_state == S_IDLE) else $error("ready outside idle");
endmodule
`default_nettype wire

### design/serial_frame_receiver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver_core
// Deframer for 0xAA / length / payload / CRC-16 / 0x55 byte streams.
// ----------------------------------------------------------------------------
// Input beats carry a command: push a received byte, read a byte of the held
// payload, or release the held frame. Every beat yields one output beat with
// status, read byte, held length and the frame and error counters.
// A four-entry command queue decouples the input from the frame engine and
// registers each command. Engine time per beat is set by the single store
// read port. A push while a frame is held, a dropped push, a read that misses,
// a release without a frame or an unused command goes straight to the output;
// a read that hits reads the store once; a push that leaves no complete frame
// scans from the head and drops noise bytes one by one. A release with a frame
// rescans the store like a push. A push that completes a frame walks the
// payload once. Each rejected start, after any CRC walk, drops one byte and rescans.
// Zero-length frames decode as soon as complete.
// Reset clears counters, store fill and held frame; capacity returns to 1025.
// A stalled output holds its beat in the result register; the engine then
// stops taking commands and the queue back-pressures the input.
// Write i_cfg_wr only while idle.
// ----------------------------------------------------------------------------
module serial_frame_receiver_core
    import sfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // op[1:0], rx_byte[9:2], read_index[19:10]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata    // status, read_data, payload_length,
                                             // frames_received, error_count
);
    logic [10:0] r_cap;
    t_cmd  w_in, w_q;
    logic  w_qv, w_qr;
    logic [1:0]  w_st;
    logic [7:0]  w_rd;
    logic [10:0] w_pl;
    logic [31:0] w_fr, w_er;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 11'(MAX_PAYLOAD + 1);
        end else if (i_cfg_wr) begin
            r_cap <= i_cfg_data;
        end
    end

    assign w_in.op         = s_axis_tdata[1:0];
    assign w_in.rx_byte    = s_axis_tdata[9:2];
    assign w_in.read_index = s_axis_tdata[19:10];

    sfr_cmd_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_valid(s_axis_tvalid), .o_wr_ready(s_axis_tready), .i_wr_data(w_in),
        .o_rd_valid(w_qv), .i_rd_ready(w_qr), .o_rd_data(w_q)
    );

    sfr_engine u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_capacity(r_cap),
        .i_cmd_valid(w_qv), .o_cmd_ready(w_qr), .i_cmd(w_q),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_status(w_st), .o_read_data(w_rd), .o_payload_length(w_pl),
        .o_frames_received(w_fr), .o_error_count(w_er)
    );

    assign m_axis_tdata = {3'd0, w_er, w_fr, w_pl, w_rd, w_st};
endmodule
`default_nettype wire
